/* hw/rtl/dpeq_pkg.sv */
package dpeq_pkg;

  // Configuration register map.
  localparam int NUM_REGS    = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int COS_W       = 18;
  localparam int GAIN_W      = 21;
  localparam int CFG_DATA_W  = 21;

  localparam logic [CFG_INDEX_W-1:0] REG_COS_A   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_A  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_B   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_B = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_B  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_GAIN = 3'd6;

  // Multiplier signal operand.
  localparam logic [2:0] MSRC_X  = 3'd0;
  localparam logic [2:0] MSRC_Y  = 3'd1;
  localparam logic [2:0] MSRC_D  = 3'd2;
  localparam logic [2:0] MSRC_Z1 = 3'd3;
  localparam logic [2:0] MSRC_Z2 = 3'd4;

  // Multiplier coefficient operand.
  localparam logic [1:0] COEF_COS   = 2'd0;
  localparam logic [1:0] COEF_WIDTH = 2'd1;
  localparam logic [1:0] COEF_GAIN  = 2'd2;
  localparam logic [1:0] COEF_OUT   = 2'd3;

  // Adder first operand.
  localparam logic [2:0] OPA_ZERO = 3'd0;
  localparam logic [2:0] OPA_X    = 3'd1;
  localparam logic [2:0] OPA_Y    = 3'd2;
  localparam logic [2:0] OPA_Z1   = 3'd3;
  localparam logic [2:0] OPA_Z2   = 3'd4;

  // Adder destination.
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_X    = 3'd1;
  localparam logic [2:0] DST_Y    = 3'd2;
  localparam logic [2:0] DST_D    = 3'd3;
  localparam logic [2:0] DST_Z    = 3'd4;
  localparam logic [2:0] DST_OUT  = 3'd5;

  // Sequencing after a step.
  localparam logic [1:0] JMP_NEXT = 2'd0;
  localparam logic [1:0] JMP_LOOP = 2'd1;
  localparam logic [1:0] JMP_DONE = 2'd2;

  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_LAST = 3'd5;

  typedef struct packed {
    logic [2:0] msrc;
    logic [1:0] coef;
    logic [2:0] opa;
    logic       neg_p;
    logic       sub_x;
    logic [2:0] dest;
    logic [1:0] jmp;
  } ctrl_t;

  // Microprogram. Words 0 to 4 run one lattice section and loop once for the
  // second section; word 5 applies the output gain.
  function automatic ctrl_t program_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    begin
      unique case (pc)
        3'd0: w = '{MSRC_Z2, COEF_WIDTH, OPA_X,    1'b1, 1'b0, DST_Y,   JMP_NEXT};
        3'd1: w = '{MSRC_Y,  COEF_WIDTH, OPA_Z2,   1'b0, 1'b1, DST_D,   JMP_NEXT};
        3'd2: w = '{MSRC_D,  COEF_GAIN,  OPA_X,    1'b1, 1'b0, DST_X,   JMP_NEXT};
        3'd3: w = '{MSRC_Z1, COEF_COS,   OPA_Y,    1'b1, 1'b0, DST_Y,   JMP_NEXT};
        3'd4: w = '{MSRC_Y,  COEF_COS,   OPA_Z1,   1'b0, 1'b0, DST_Z,   JMP_LOOP};
        3'd5: w = '{MSRC_X,  COEF_OUT,   OPA_ZERO, 1'b0, 1'b0, DST_OUT, JMP_DONE};
        default: w = '{MSRC_X, COEF_OUT, OPA_ZERO, 1'b0, 1'b0, DST_NONE, JMP_DONE};
      endcase
      return w;
    end
  endfunction

endpackage

/* hw/rtl/dpeq_in_if.sv */
interface dpeq_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

/* hw/rtl/dpeq_out_if.sv */
interface dpeq_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output last_out, output clipped,
                  input ready);
  modport sink (input valid, input sample_out, input last_out, input clipped,
                output ready);
endinterface

/* hw/rtl/dpeq_mul.sv */
module dpeq_mul #(
  parameter int A_BITS = 28,
  parameter int B_BITS = 21,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [A_BITS-1:0]             a,
  input  logic signed [B_BITS-1:0]             b,
  output logic signed [A_BITS+B_BITS-FRAC_BITS-1:0] p
);
  localparam int PROD_W = A_BITS + B_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;

  // Round half up, then floor shift: a part-select of the two's complement sum.
  assign prod    = PROD_W'(a) * PROD_W'(b);
  assign rounded = prod + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= rounded[PROD_W-1:FRAC_BITS];
    end
  end
endmodule

/* hw/rtl/dual_parametric_eq_cascade.sv */
// Two cascaded peaking equalizer sections (allpass lattice form) followed by
// an output gain. One signed sample enters per input beat and one equalized,
// saturated sample leaves per output beat, with the block mark copied and a
// clipped flag that is set when the sample or any internal value saturated.
// Coefficients are written through the configuration port; the user is to
// write them only while the block is idle, as the block does not enforce it.
// The cosine and bandwidth terms are Q1.COEF_FRAC_BITS, the gain terms carry
// extra integer bits. All eleven products of a sample go through one shared
// multiplier under control of a six-word microprogram; each word has a
// multiply phase and then an add and branch phase. The next sample is taken
// once the last word of the previous one has written the output register.
// The finished sample sits in an output register, so a new sample is accepted
// while the previous result still waits to be taken; that sample then holds
// at its last step until the output register is free.
module dual_parametric_eq_cascade #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS = 28,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  dpeq_in_if.sink                              in_ch,
  dpeq_out_if.source                           out_ch,
  input  logic                                 cfg_write,
  input  logic [dpeq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpeq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Coefficients are held at one common width so that the multiplier sees a
  // single operand format; it also has room for the unity output gain.
  localparam int COEF_BITS = (dpeq_pkg::GAIN_W > COEF_FRAC_BITS + 2) ?
                             dpeq_pkg::GAIN_W : COEF_FRAC_BITS + 2;
  localparam int PROD_BITS = STATE_BITS + COEF_BITS - COEF_FRAC_BITS;
  // The adder works wide enough for three terms and for the output range.
  localparam int SUM_BITS  = ((PROD_BITS > SAMPLE_BITS) ? PROD_BITS : SAMPLE_BITS) + 2;

  localparam logic signed [SUM_BITS-1:0] ST_MAX = (SUM_BITS'(1) <<< (STATE_BITS - 1)) - 1;
  localparam logic signed [SUM_BITS-1:0] ST_MIN = -ST_MAX - 1;
  localparam logic signed [SUM_BITS-1:0] SMP_MAX = (SUM_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [SUM_BITS-1:0] SMP_MIN = -SMP_MAX - 1;

  // Saturation to the state width; the top bit reports a clip.
  function automatic logic [STATE_BITS:0] sat_state(input logic signed [SUM_BITS-1:0] v);
    logic signed [STATE_BITS-1:0] r;
    logic c;
    begin
      c = 1'b1;
      if (v > ST_MAX) begin
        r = ST_MAX[STATE_BITS-1:0];
      end else if (v < ST_MIN) begin
        r = ST_MIN[STATE_BITS-1:0];
      end else begin
        r = v[STATE_BITS-1:0];
        c = 1'b0;
      end
      return {c, r};
    end
  endfunction

  // Configuration registers.
  logic signed [COEF_BITS-1:0] cos_a, width_a, gain_a;
  logic signed [COEF_BITS-1:0] cos_b, width_b, gain_b;
  logic signed [COEF_BITS-1:0] out_gain;

  // Lattice state, one entry per section.
  logic signed [STATE_BITS-1:0] lattice_first [2];
  logic signed [STATE_BITS-1:0] lattice_second [2];

  // Working registers of the datapath.
  logic signed [STATE_BITS-1:0] x_reg, y_reg, d_reg;
  logic                         last_reg;
  logic                         clip_reg;

  // Sequencer.
  logic                         busy;
  logic                         phase;   // 0: multiply, 1: add and branch
  logic                         sect;    // 0: first section, 1: second
  logic [dpeq_pkg::PC_W-1:0]    pc;
  dpeq_pkg::ctrl_t              ctrl;

  // Output register.
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_last;
  logic                          out_clip;

  logic                          in_accept;
  logic                          out_blocked;
  logic                          step;
  logic                          mul_en;
  logic signed [STATE_BITS-1:0]  z1, z2;
  logic signed [STATE_BITS-1:0]  mul_a;
  logic signed [COEF_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SUM_BITS-1:0]    p_ext, opa_ext, x_ext, sum;
  logic signed [SUM_BITS-1:0]    sample_ext;
  logic [STATE_BITS:0]           sum_st;
  logic [STATE_BITS:0]           sample_st;
  logic signed [SAMPLE_BITS-1:0] sum_out;
  logic                          sum_out_clip;

  assign ctrl        = dpeq_pkg::program_word(pc);
  assign in_ch.ready = !busy;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // The last step writes the output register; it waits while that register
  // still holds a beat that has not been taken.
  assign out_blocked = (ctrl.jmp == dpeq_pkg::JMP_DONE) && out_valid && !out_ch.ready;
  assign mul_en      = busy && !phase;
  assign step        = busy && phase && !out_blocked;

  assign z1 = lattice_first[sect];
  assign z2 = lattice_second[sect];

  always_comb begin
    unique case (ctrl.msrc)
      dpeq_pkg::MSRC_Y:  mul_a = y_reg;
      dpeq_pkg::MSRC_D:  mul_a = d_reg;
      dpeq_pkg::MSRC_Z1: mul_a = z1;
      dpeq_pkg::MSRC_Z2: mul_a = z2;
      default:           mul_a = x_reg;
    endcase
  end

  always_comb begin
    unique case (ctrl.coef)
      dpeq_pkg::COEF_COS:   mul_b = sect ? cos_b : cos_a;
      dpeq_pkg::COEF_WIDTH: mul_b = sect ? width_b : width_a;
      dpeq_pkg::COEF_GAIN:  mul_b = sect ? gain_b : gain_a;
      default:              mul_b = out_gain;
    endcase
  end

  dpeq_mul #(
    .A_BITS(STATE_BITS),
    .B_BITS(COEF_BITS),
    .FRAC_BITS(COEF_FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .en(mul_en),
    .a(mul_a),
    .b(mul_b),
    .p(prod)
  );

  always_comb begin
    unique case (ctrl.opa)
      dpeq_pkg::OPA_X:  opa_ext = SUM_BITS'(x_reg);
      dpeq_pkg::OPA_Y:  opa_ext = SUM_BITS'(y_reg);
      dpeq_pkg::OPA_Z1: opa_ext = SUM_BITS'(z1);
      dpeq_pkg::OPA_Z2: opa_ext = SUM_BITS'(z2);
      default:          opa_ext = '0;
    endcase
  end

  assign p_ext  = SUM_BITS'(prod);
  assign x_ext  = ctrl.sub_x ? SUM_BITS'(x_reg) : '0;
  assign sum    = opa_ext + (ctrl.neg_p ? -p_ext : p_ext) - x_ext;
  assign sum_st = sat_state(sum);

  // Output saturation to the sample width.
  always_comb begin
    sum_out_clip = 1'b1;
    if (sum > SMP_MAX) begin
      sum_out = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (sum < SMP_MIN) begin
      sum_out = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      sum_out = sum[SAMPLE_BITS-1:0];
      sum_out_clip = 1'b0;
    end
  end

  // The incoming sample is first held to the state width.
  assign sample_ext = SUM_BITS'(in_ch.sample_in);
  assign sample_st  = sat_state(sample_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_a      <= '0;
      width_a    <= '0;
      gain_a     <= '0;
      cos_b      <= '0;
      width_b    <= '0;
      gain_b     <= '0;
      out_gain   <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
      lattice_first[0]  <= '0;
      lattice_first[1]  <= '0;
      lattice_second[0] <= '0;
      lattice_second[1] <= '0;
      busy       <= 1'b0;
      phase      <= 1'b0;
      sect       <= 1'b0;
      pc         <= '0;
      out_valid  <= 1'b0;
      clip_reg   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          dpeq_pkg::REG_COS_A:    cos_a   <= COEF_BITS'($signed(cfg_data[dpeq_pkg::COS_W-1:0]));
          dpeq_pkg::REG_WIDTH_A:  width_a <= COEF_BITS'($signed(cfg_data[dpeq_pkg::COS_W-1:0]));
          dpeq_pkg::REG_GAIN_A:   gain_a  <= COEF_BITS'($signed(cfg_data[dpeq_pkg::GAIN_W-1:0]));
          dpeq_pkg::REG_COS_B:    cos_b   <= COEF_BITS'($signed(cfg_data[dpeq_pkg::COS_W-1:0]));
          dpeq_pkg::REG_WIDTH_B:  width_b <= COEF_BITS'($signed(cfg_data[dpeq_pkg::COS_W-1:0]));
          dpeq_pkg::REG_GAIN_B:   gain_b  <= COEF_BITS'($signed(cfg_data[dpeq_pkg::GAIN_W-1:0]));
          dpeq_pkg::REG_OUT_GAIN: out_gain <= COEF_BITS'($signed(cfg_data[dpeq_pkg::GAIN_W-1:0]));
          default: ;
        endcase
      end

      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (in_accept) begin
        x_reg    <= sample_st[STATE_BITS-1:0];
        clip_reg <= sample_st[STATE_BITS];
        last_reg <= in_ch.last_in;
        busy     <= 1'b1;
        phase    <= 1'b0;
        sect     <= 1'b0;
        pc       <= '0;
      end else if (mul_en) begin
        phase <= 1'b1;
      end else if (step) begin
        phase <= 1'b0;

        if (ctrl.dest != dpeq_pkg::DST_NONE && ctrl.dest != dpeq_pkg::DST_OUT) begin
          clip_reg <= clip_reg | sum_st[STATE_BITS];
        end

        unique case (ctrl.dest)
          dpeq_pkg::DST_X: x_reg <= sum_st[STATE_BITS-1:0];
          dpeq_pkg::DST_Y: y_reg <= sum_st[STATE_BITS-1:0];
          dpeq_pkg::DST_D: d_reg <= sum_st[STATE_BITS-1:0];
          dpeq_pkg::DST_Z: begin
            lattice_second[sect] <= sum_st[STATE_BITS-1:0];
            lattice_first[sect]  <= y_reg;
          end
          dpeq_pkg::DST_OUT: begin
            out_sample <= sum_out;
            out_last   <= last_reg;
            out_clip   <= clip_reg | sum_out_clip;
          end
          default: ;
        endcase

        unique case (ctrl.jmp)
          dpeq_pkg::JMP_LOOP: begin
            if (!sect) begin
              sect <= 1'b1;
              pc   <= '0;
            end else begin
              pc <= pc + 1'b1;
            end
          end
          dpeq_pkg::JMP_DONE: begin
            busy      <= 1'b0;
            out_valid <= 1'b1;
          end
          default: pc <= pc + 1'b1;
        endcase
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.last_out   = out_last;
  assign out_ch.clipped    = out_clip;

  // Every sample starts at the top of the program in the first section.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (pc == '0) && !phase && !sect && busy)
    else $error("sample did not start at the top of the program");

  // The section index only advances on the loop word.
  a_sect: assert property (@(posedge clk) disable iff (rst)
    $rose(sect) |-> $past(ctrl.jmp == dpeq_pkg::JMP_LOOP) && $past(step))
    else $error("section switched outside the loop word");

  // The program counter never leaves the program.
  a_pc: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= dpeq_pkg::PC_LAST)
    else $error("program counter out of range");

  // A result appears only after both sections have run.
  a_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && $past(sect) && !busy)
    else $error("output beat without a finished program");

endmodule

/* verif/tb_dual_parametric_eq_cascade.sv */
module tb_dual_parametric_eq_cascade;

  localparam int SAMPLE_BITS    = 24;
  localparam int STATE_BITS     = 28;
  localparam int COEF_FRAC_BITS = 16;

  localparam int NUM_REGS    = dpeq_pkg::NUM_REGS;
  localparam int CFG_INDEX_W = dpeq_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = dpeq_pkg::CFG_DATA_W;
  localparam int COS_W       = dpeq_pkg::COS_W;
  localparam int GAIN_W      = dpeq_pkg::GAIN_W;

  // Quiet time after the last output beat, long enough to cover anything
  // still in flight.
  localparam int SETTLE_CYCLES = 30;

  // The slowest correct run is roughly 2000 samples with the longest gaps and
  // stalls; this limit is several times the length of such a run.
  localparam int CYCLE_LIMIT = 800000;

  // The receiver stops taking results for a long stretch when it has taken
  // this many output beats, so that the block backs up and stalls its input.
  localparam int HOLD_MARK_EARLY = 60;
  localparam int HOLD_MARK_LATE  = 1200;

  // Index 7 is not mapped to any register; writes there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam int RANDOM_PHASES     = 8;
  localparam int SAMPLES_PER_PHASE = 240;

  typedef enum int {SHAPE_NOISE, SHAPE_QUIET, SHAPE_IMPULSE, SHAPE_DC, SHAPE_RAIL} shape_t;
  typedef enum int {CFG_GENTLE, CFG_WILD, CFG_CORNER} cfg_style_t;
  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_BURSTY, DRAIN_PERIODIC} drain_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } audio_beat_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          clipped;
  } eq_result_t;

  // Our own copy of the coefficient registers, at the widths of the block.
  typedef struct {
    logic signed [COS_W-1:0]  cos_a;
    logic signed [COS_W-1:0]  width_a;
    logic signed [GAIN_W-1:0] gain_a;
    logic signed [COS_W-1:0]  cos_b;
    logic signed [COS_W-1:0]  width_b;
    logic signed [GAIN_W-1:0] gain_b;
    logic signed [GAIN_W-1:0] out_gain;
  } eq_coefs_t;

  logic clk;
  logic rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dpeq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  dpeq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  dual_parametric_eq_cascade #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .STATE_BITS(STATE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Samples waiting for the driver, and the results the predictor expects
  // back, oldest first.
  audio_beat_t samples_to_send[$];
  eq_result_t  predicted_results[$];

  eq_coefs_t coefs;
  longint    lat_a1, lat_a2, lat_b1, lat_b2;

  int   samples_queued = 0;
  int   out_beats = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  logic in_fire = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Saturate to a signed width, and flag the sample as clipped if it had to.
  function automatic longint clamp(input longint v, input int w, inout bit clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Signal times coefficient, rounded half up: add half an LSB of the
  // coefficient fraction and shift right with floor.
  function automatic longint coef_mul(input longint s, input longint c);
    longint p;
    p = s * c + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    return p >>> COEF_FRAC_BITS;
  endfunction

  // One peaking section: the allpass lattice runs on its two registers, and
  // the section output is the input minus the gain term times the difference
  // between the allpass output and the input. Every sum saturates.
  function automatic longint peak_section(input longint x, inout longint z1, inout longint z2,
                                          input longint cosv, input longint widv,
                                          input longint gain, inout bit clip);
    longint node;
    longint diff;
    longint result;
    node   = clamp(x - coef_mul(z2, widv), STATE_BITS, clip);
    diff   = clamp(z2 + coef_mul(node, widv) - x, STATE_BITS, clip);
    result = clamp(x - coef_mul(diff, gain), STATE_BITS, clip);
    node   = clamp(node - coef_mul(z1, cosv), STATE_BITS, clip);
    z2     = clamp(z1 + coef_mul(node, cosv), STATE_BITS, clip);
    z1     = node;
    return result;
  endfunction

  // Runs one accepted sample through both sections and the output gain,
  // advancing the lattice state the way the block must.
  function automatic eq_result_t equalize_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                                                 input logic last);
    eq_result_t r;
    bit         clip;
    longint     x;
    clip = 1'b0;
    x = clamp(longint'(sample), STATE_BITS, clip);
    x = peak_section(x, lat_a1, lat_a2, coefs.cos_a, coefs.width_a, coefs.gain_a, clip);
    x = peak_section(x, lat_b1, lat_b2, coefs.cos_b, coefs.width_b, coefs.gain_b, clip);
    x = clamp(coef_mul(x, coefs.out_gain), SAMPLE_BITS, clip);
    r.sample  = x[SAMPLE_BITS-1:0];
    r.last    = last;
    r.clipped = clip;
    return r;
  endfunction

  // Mirrors a register write into our copy. Each register keeps only its low
  // bits, sign extended; an unmapped index changes nothing.
  function automatic void store_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      dpeq_pkg::REG_COS_A:    coefs.cos_a    = data[COS_W-1:0];
      dpeq_pkg::REG_WIDTH_A:  coefs.width_a  = data[COS_W-1:0];
      dpeq_pkg::REG_GAIN_A:   coefs.gain_a   = data[GAIN_W-1:0];
      dpeq_pkg::REG_COS_B:    coefs.cos_b    = data[COS_W-1:0];
      dpeq_pkg::REG_WIDTH_B:  coefs.width_b  = data[COS_W-1:0];
      dpeq_pkg::REG_GAIN_B:   coefs.gain_b   = data[GAIN_W-1:0];
      dpeq_pkg::REG_OUT_GAIN: coefs.out_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t error: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung block never finishes its phases, so the run is cut off here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------

  // Everything changes on the falling edge. The driver holds a beat until it
  // has been taken, then pulls the next sample from the queue. It sends in
  // bursts of random length with random gaps in between; a zero gap is common
  // so there are also long stretches of back to back beats.
  int          burst_left = 0;
  int          gap_left = 0;
  logic        offering;
  audio_beat_t next_beat;

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // The beat on the bus stays up until a rising edge has taken it.
      offering = in_ch.valid && !in_fire;
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_to_send.size() > 0) begin
          next_beat = samples_to_send.pop_front();
          in_ch.sample_in <= next_beat.sample;
          in_ch.last_in   <= next_beat.last;
          offering = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, $urandom_range(1, 40));
          end
        end
      end
      in_ch.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------
  // Output receiver
  // ---------------------------------------------------------------------

  // The receiver runs through stall modes of random length: always ready,
  // a coin toss per cycle, mostly ready with occasional long stalls, and a
  // fixed period. At two points in the run it holds off for a random stretch,
  // counted here, while the driver keeps offering samples.
  drain_t drain_mode = DRAIN_FREE;
  int     mode_left = 0;
  int     stall_left = 0;
  int     period = 1;
  int     tick = 0;
  int     hold_left = 0;
  int     hold_mark = -1;
  logic   take_next;

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        take_next = 1'b0;
      end else if ((out_beats == HOLD_MARK_EARLY || out_beats == HOLD_MARK_LATE) &&
                   hold_mark != out_beats) begin
        hold_mark = out_beats;
        hold_left = $urandom_range(400, 700);
        take_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          drain_mode = drain_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 300);
          period     = $urandom_range(2, 6);
          stall_left = 0;
        end
        mode_left--;
        tick++;
        case (drain_mode)
          DRAIN_FREE: take_next = 1'b1;
          DRAIN_COIN: take_next = ($urandom_range(0, 1) == 1);
          DRAIN_BURSTY: begin
            if (stall_left > 0) begin
              stall_left--;
              take_next = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
              stall_left = $urandom_range(1, 60);
              take_next = 1'b0;
            end else begin
              take_next = 1'b1;
            end
          end
          default: take_next = (tick % period == 0);
        endcase
      end
      out_ch.ready <= take_next;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------

  // Sampled on the rising edge, where both channels hand over their beats.
  // The output beat is checked before the input beat of the same edge is
  // predicted, since it can only belong to an earlier sample.
  eq_result_t want;

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with no sample outstanding", out_beats));
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.sample_out !== want.sample) begin
            report_mismatch($sformatf("beat %0d sample_out %0d, expected %0d",
                                      out_beats, out_ch.sample_out, want.sample));
          end
          if (out_ch.last_out !== want.last) begin
            report_mismatch($sformatf("beat %0d last_out %b, expected %b",
                                      out_beats, out_ch.last_out, want.last));
          end
          if (out_ch.clipped !== want.clipped) begin
            report_mismatch($sformatf("beat %0d clipped %b, expected %b",
                                      out_beats, out_ch.clipped, want.clipped));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(equalize_sample(in_ch.sample_in, in_ch.last_in));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] sample, input logic last);
    audio_beat_t b;
    b.sample = sample;
    b.last   = last;
    samples_to_send.push_back(b);
    samples_queued++;
  endtask

  // Drives one register write on the next falling edge. The 18-bit registers
  // get junk in the unused top data bits, which the block must ignore. The
  // caller lowers the write enable after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint value);
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           junk;
    data = value[CFG_DATA_W-1:0];
    junk = $urandom;
    if (idx == REG_UNUSED) begin
      data = junk[CFG_DATA_W-1:0];
    end else if (idx != dpeq_pkg::REG_GAIN_A && idx != dpeq_pkg::REG_GAIN_B &&
                 idx != dpeq_pkg::REG_OUT_GAIN) begin
      data[CFG_DATA_W-1:COS_W] = junk[CFG_DATA_W-COS_W-1:0];
    end
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    store_reg(idx, data);
  endtask

  // Writes all seven registers, optionally pokes the unmapped index too, and
  // releases the port.
  task automatic write_all(input longint vals [NUM_REGS], input bit poke_unused);
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(i[CFG_INDEX_W-1:0], vals[i]);
    end
    if (poke_unused) begin
      write_reg(REG_UNUSED, 0);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic longint rand_signed(input int w);
    return longint'($urandom_range(0, (1 << w) - 1)) - (longint'(1) <<< (w - 1));
  endfunction

  // Extremes, zero, minus one or anything in range.
  function automatic longint corner_value(input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    case ($urandom_range(0, 4))
      0: return hi;
      1: return -hi - 1;
      2: return 0;
      3: return -1;
      default: return rand_signed(w);
    endcase
  endfunction

  // Gentle settings keep both lattices stable (terms within plus or minus
  // one) with moderate gains, so the filters ring and settle the way real
  // equalizers do and saturation only comes from loud input. Wild settings
  // use the full register range and saturate freely.
  task automatic configure(input cfg_style_t style);
    longint vals [NUM_REGS];
    case (style)
      CFG_GENTLE: begin
        vals[dpeq_pkg::REG_COS_A]    = longint'($urandom_range(0, 131072)) - 65536;
        vals[dpeq_pkg::REG_WIDTH_A]  = longint'($urandom_range(0, 130000)) - 65000;
        vals[dpeq_pkg::REG_GAIN_A]   = longint'($urandom_range(0, 262144)) - 32768;
        vals[dpeq_pkg::REG_COS_B]    = longint'($urandom_range(0, 131072)) - 65536;
        vals[dpeq_pkg::REG_WIDTH_B]  = longint'($urandom_range(0, 130000)) - 65000;
        vals[dpeq_pkg::REG_GAIN_B]   = longint'($urandom_range(0, 262144)) - 32768;
        vals[dpeq_pkg::REG_OUT_GAIN] = longint'($urandom_range(16384, 131072));
      end
      CFG_WILD: begin
        vals[dpeq_pkg::REG_COS_A]    = rand_signed(COS_W);
        vals[dpeq_pkg::REG_WIDTH_A]  = rand_signed(COS_W);
        vals[dpeq_pkg::REG_GAIN_A]   = rand_signed(GAIN_W);
        vals[dpeq_pkg::REG_COS_B]    = rand_signed(COS_W);
        vals[dpeq_pkg::REG_WIDTH_B]  = rand_signed(COS_W);
        vals[dpeq_pkg::REG_GAIN_B]   = rand_signed(GAIN_W);
        vals[dpeq_pkg::REG_OUT_GAIN] = rand_signed(GAIN_W);
      end
      default: begin
        vals[dpeq_pkg::REG_COS_A]    = corner_value(COS_W);
        vals[dpeq_pkg::REG_WIDTH_A]  = corner_value(COS_W);
        vals[dpeq_pkg::REG_GAIN_A]   = corner_value(GAIN_W);
        vals[dpeq_pkg::REG_COS_B]    = corner_value(COS_W);
        vals[dpeq_pkg::REG_WIDTH_B]  = corner_value(COS_W);
        vals[dpeq_pkg::REG_GAIN_B]   = corner_value(GAIN_W);
        vals[dpeq_pkg::REG_OUT_GAIN] = corner_value(GAIN_W);
      end
    endcase
    write_all(vals, $urandom_range(0, 1));
  endtask

  // Fills the queue with segments of audio-like material: white noise over
  // the full range, quiet noise, impulses followed by silence (which shows
  // the ringing of the lattices), DC steps, and rail to rail swings. The
  // block mark is set now and then, often at a segment end.
  task automatic queue_program(input int count);
    shape_t                        shape;
    int                            seg_left;
    bit                            seg_start;
    logic [31:0]                   r;
    logic signed [SAMPLE_BITS-1:0] level;
    logic signed [SAMPLE_BITS-1:0] s;
    logic                          mark;
    seg_left  = 0;
    seg_start = 1'b0;
    shape     = SHAPE_NOISE;
    level     = '0;
    for (int k = 0; k < count; k++) begin
      if (seg_left == 0) begin
        shape     = shape_t'($urandom_range(0, 4));
        seg_left  = $urandom_range(4, 40);
        seg_start = 1'b1;
        r         = $urandom;
        level     = r[SAMPLE_BITS-1:0];
      end
      r = $urandom;
      case (shape)
        SHAPE_NOISE:   s = r[SAMPLE_BITS-1:0];
        SHAPE_QUIET:   s = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
        SHAPE_IMPULSE: s = seg_start ? level : '0;
        SHAPE_DC:      s = level;
        default:       s = r[0] ? SAMPLE_MAX : SAMPLE_MIN;
      endcase
      mark = (seg_left == 1) ? r[31] : ($urandom_range(0, 15) == 0);
      queue_sample(s, mark);
      seg_left--;
      seg_start = 1'b0;
    end
  endtask

  // Configuration may only change while nothing is in flight: every queued
  // sample must have come back, plus a short settle.
  task automatic wait_drained();
    while (out_beats < samples_queued) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  longint vals [NUM_REGS];

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.last_in   = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    rst             = 1'b1;

    // Predictor starts from the reset state: all zero, unity output gain.
    coefs = '{default: '0};
    coefs.out_gain = GAIN_W'(1) << COEF_FRAC_BITS;
    lat_a1 = 0;
    lat_a2 = 0;
    lat_b1 = 0;
    lat_b2 = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset coefficients: both sections are transparent and the output gain
    // is unity, so every sample must come back unchanged and unclipped.
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(-24'sd1, 1'b0);
    queue_sample(24'sd1, 1'b0);
    queue_sample(24'sh555555, 1'b1);
    queue_sample(24'shAAAAAA, 1'b0);
    wait_drained();

    // Every register at its top value: state and output saturate hard.
    vals[dpeq_pkg::REG_COS_A]    = (1 << (COS_W - 1)) - 1;
    vals[dpeq_pkg::REG_WIDTH_A]  = (1 << (COS_W - 1)) - 1;
    vals[dpeq_pkg::REG_GAIN_A]   = (1 << (GAIN_W - 1)) - 1;
    vals[dpeq_pkg::REG_COS_B]    = (1 << (COS_W - 1)) - 1;
    vals[dpeq_pkg::REG_WIDTH_B]  = (1 << (COS_W - 1)) - 1;
    vals[dpeq_pkg::REG_GAIN_B]   = (1 << (GAIN_W - 1)) - 1;
    vals[dpeq_pkg::REG_OUT_GAIN] = (1 << (GAIN_W - 1)) - 1;
    write_all(vals, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    queue_sample('0, 1'b0);
    queue_sample(24'sd1, 1'b0);
    queue_sample(-24'sd1, 1'b1);
    wait_drained();

    // Every register at its bottom value.
    vals[dpeq_pkg::REG_COS_A]    = -(1 << (COS_W - 1));
    vals[dpeq_pkg::REG_WIDTH_A]  = -(1 << (COS_W - 1));
    vals[dpeq_pkg::REG_GAIN_A]   = -(1 << (GAIN_W - 1));
    vals[dpeq_pkg::REG_COS_B]    = -(1 << (COS_W - 1));
    vals[dpeq_pkg::REG_WIDTH_B]  = -(1 << (COS_W - 1));
    vals[dpeq_pkg::REG_GAIN_B]   = -(1 << (GAIN_W - 1));
    vals[dpeq_pkg::REG_OUT_GAIN] = -(1 << (GAIN_W - 1));
    write_all(vals, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(-24'sd1, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    wait_drained();

    // A stable boost filter, then a write to the unmapped index that must
    // not disturb it. A full scale impulse shows the filter ringing out.
    vals[dpeq_pkg::REG_COS_A]    = -32768;
    vals[dpeq_pkg::REG_WIDTH_A]  = 52000;
    vals[dpeq_pkg::REG_GAIN_A]   = 49152;
    vals[dpeq_pkg::REG_COS_B]    = 45000;
    vals[dpeq_pkg::REG_WIDTH_B]  = -30000;
    vals[dpeq_pkg::REG_GAIN_B]   = -16384;
    vals[dpeq_pkg::REG_OUT_GAIN] = 98304;
    write_all(vals, 1'b1);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    wait_drained();

    // Random phases: gentle filters most often, wild and corner settings in
    // between, each phase with a fresh full set of registers. The state of
    // the lattices carries over from phase to phase.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        1:       configure(CFG_WILD);
        3:       configure(CFG_CORNER);
        default: configure(CFG_GENTLE);
      endcase
      queue_program(SAMPLES_PER_PHASE);
      wait_drained();
    end

    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                predicted_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dpeq_pkg.sv
hw/rtl/dpeq_in_if.sv
hw/rtl/dpeq_out_if.sv
hw/rtl/dpeq_mul.sv
hw/rtl/dual_parametric_eq_cascade.sv
verif/tb_dual_parametric_eq_cascade.sv
